@@ design/cckb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cckb_pkg: shared types and constants of the clipped color-key blit engine
// Field widths, stream word layouts, register indexes, the clip helper and
// the command record that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package cckb_pkg;

	// Field widths
	localparam int DIM_W      = 13;
	localparam int COORD_W    = 12;
	localparam int IDX_W      = 24;
	localparam int PIX_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Parameter defaults
	localparam int MAX_DIM_DEF    = 4096;
	localparam int PIXEL_BITS_DEF = 32;

	// Depth of the queue between the front and back parts
	localparam int QUEUE_DEPTH = 2;

	// Input word layout (tuser carries func)
	localparam int IN_SRC_X_LSB  = 0;
	localparam int IN_SRC_Y_LSB  = 12;
	localparam int IN_RECT_W_LSB = 24;
	localparam int IN_RECT_H_LSB = 37;
	localparam int IN_DST_X_LSB  = 50;
	localparam int IN_DST_Y_LSB  = 62;
	localparam int IN_PIXEL_LSB  = 74;
	localparam int IN_TDATA_W    = 112;

	// Output word layout (tlast carries last_pixel)
	localparam int OUT_TDATA_W = 112;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (2 * IDX_W + PIX_W + 1 + 2 * DIM_W + 1);

	// Register reset values
	localparam logic [DIM_W-1:0] SOURCE_WIDTH_RST   = 13'd1024;
	localparam logic [DIM_W-1:0] SOURCE_HEIGHT_RST  = 13'd768;
	localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST   = 13'd1024;
	localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST  = 13'd768;
	localparam logic [DIM_W-1:0] SCANLINE_PITCH_RST = 13'd1024;
	localparam logic [PIX_W-1:0] COLOR_KEY_RST      = 32'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH   = 3'd0,
		REG_SOURCE_HEIGHT  = 3'd1,
		REG_SCREEN_WIDTH   = 3'd2,
		REG_SCREEN_HEIGHT  = 3'd3,
		REG_SCANLINE_PITCH = 3'd4,
		REG_COLOR_KEY      = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		FUNC_COMMAND = 1'b0,
		FUNC_PIXEL   = 1'b1
	} func_t;

	// Configuration register set
	typedef struct packed {
		logic [DIM_W-1:0] source_width;
		logic [DIM_W-1:0] source_height;
		logic [DIM_W-1:0] screen_width;
		logic [DIM_W-1:0] screen_height;
		logic [DIM_W-1:0] scanline_pitch;
		logic [PIX_W-1:0] color_key;
	} cfg_t;

	// Classified command as handed to the back part
	typedef struct packed {
		logic             empty;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [IDX_W-1:0] dest_base;
		logic [IDX_W-1:0] source_base;
	} cmd_t;

	// Length of the part of [start, start + len) that lies below limit.
	function automatic logic [DIM_W-1:0] clip_span(input logic [DIM_W-1:0] start,
			input logic [DIM_W-1:0] len, input logic [DIM_W-1:0] limit);
		logic [DIM_W:0] end_v;
		logic [DIM_W:0] span_v;
		end_v = {1'b0, start} + {1'b0, len};
		if (end_v > {1'b0, limit}) begin
			end_v = {1'b0, limit};
		end
		span_v = end_v - {1'b0, start};
		if (start >= limit) begin
			span_v = '0;
		end
		return span_v[DIM_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ design/clipped_color_key_blit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_color_key_blit: 2D blit engine with clipping and color keying
// Top level: configuration registers, input stage, queue and back end.
// ----------------------------------------------------------------------------
// The engine takes one word per clock on the input stream, commands and
// pixels alike, while the input is not stalled, and gives one result word
// per clock while the output side takes them. A word is registered in the
// input stage when it is accepted, is then written into the queue and from
// there moves into the output register, from which its result is offered;
// pixel words follow the same path. The input stage holds one multiplier
// per start index, so the clip and index work for a command fits in the
// input stage. A two-word queue between the input stage and the back end
// lets each side stall on its own: while a result waits in the output
// register and the output side does not take it, the back end takes
// nothing, and the queue and input stage absorb up to three more words
// before the input stalls. Pixel words that arrive with no blit running are
// consumed without a result. Configuration writes are taken on every clock
// and must only be issued while no word is in flight.
module clipped_color_key_blit
	import cckb_pkg::*;
#(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
)(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration write channel
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// Input stream
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// src_x[11:0], src_y[23:12], rect_width[36:24], rect_height[49:37],
	// dst_x[61:50], dst_y[73:62], pixel_value[105:74], zero[111:106]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// func[0]
	input  wire logic                   s_axis_tuser,
	// Output stream
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// dest_index[23:0], source_index[47:24], write_pixel[79:48],
	// write_enable[80], clip_width[93:81], clip_height[106:94],
	// empty_res[107], zero[111:108]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	// last_pixel
	output logic                        m_axis_tlast
);

	localparam int QDATA_W = 1 + $bits(cmd_t) + PIXEL_BITS;

	cfg_t               cfg;
	logic               push_valid;
	logic               push_ready;
	logic [QDATA_W-1:0] push_data;
	logic               pop_valid;
	logic               pop_ready;
	logic [QDATA_W-1:0] pop_data;

	// Configuration registers
	cckb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input stage: clip and classify
	cckb_front #(
		.MAX_DIM    (MAX_DIM),
		.PIXEL_BITS (PIXEL_BITS),
		.QDATA_W    (QDATA_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_func    (s_axis_tuser),
		.in_data    (s_axis_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// Queue between the two parts
	cckb_queue #(
		.DATA_W (QDATA_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Back end: raster walk and results
	cckb_back #(
		.PIXEL_BITS (PIXEL_BITS),
		.QDATA_W    (QDATA_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
`default_nettype wire

@@ design/cckb_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cckb_cfg: configuration register file
// Holds the surface, screen, pitch and key registers written over the
// configuration channel. The channel is always ready.
// ----------------------------------------------------------------------------
module cckb_cfg
	import cckb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign cfg       = regs_q;

	// Register writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.source_width   <= SOURCE_WIDTH_RST;
			regs_q.source_height  <= SOURCE_HEIGHT_RST;
			regs_q.screen_width   <= SCREEN_WIDTH_RST;
			regs_q.screen_height  <= SCREEN_HEIGHT_RST;
			regs_q.scanline_pitch <= SCANLINE_PITCH_RST;
			regs_q.color_key      <= COLOR_KEY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SOURCE_WIDTH:   regs_q.source_width   <= cfg_data[DIM_W-1:0];
				REG_SOURCE_HEIGHT:  regs_q.source_height  <= cfg_data[DIM_W-1:0];
				REG_SCREEN_WIDTH:   regs_q.screen_width   <= cfg_data[DIM_W-1:0];
				REG_SCREEN_HEIGHT:  regs_q.screen_height  <= cfg_data[DIM_W-1:0];
				REG_SCANLINE_PITCH: regs_q.scanline_pitch <= cfg_data[DIM_W-1:0];
				REG_COLOR_KEY:      regs_q.color_key      <= cfg_data[PIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/cckb_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cckb_front: input stage of the blit engine
// Accepts words, clips commands against the source surface and the screen,
// forms the start indices, and pushes classified words into the queue.
// ----------------------------------------------------------------------------
module cckb_front
	import cckb_pkg::*;
#(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	parameter int QDATA_W    = 1 + $bits(cmd_t) + PIXEL_BITS
)(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  in_func,
	input  wire logic [IN_TDATA_W-1:0] in_data,
	output logic                       push_valid,
	input  wire logic                  push_ready,
	output logic [QDATA_W-1:0]         push_data
);

	logic [COORD_W-1:0] src_x;
	logic [COORD_W-1:0] src_y;
	logic [DIM_W-1:0]   rect_w;
	logic [DIM_W-1:0]   rect_h;
	logic [COORD_W-1:0] dst_x;
	logic [COORD_W-1:0] dst_y;
	logic [IDX_W:0]     dest_prod;
	logic [IDX_W:0]     src_prod;

	logic                  valid_s1;
	logic                  func_s1;
	logic [DIM_W-1:0]      w_s1;
	logic [DIM_W-1:0]      h_s1;
	logic [COORD_W-1:0]    dx_s1;
	logic [COORD_W-1:0]    dy_s1;
	logic [COORD_W-1:0]    sx_s1;
	logic [IDX_W-1:0]      dprod_s1;
	logic [IDX_W-1:0]      sprod_s1;
	logic [PIXEL_BITS-1:0] pixel_s1;

	logic [DIM_W-1:0] w_scr;
	logic [DIM_W-1:0] h_scr;
	logic [DIM_W-1:0] w_sat;
	logic [DIM_W-1:0] h_sat;
	cmd_t             cmd;

	// Input field extraction
	assign src_x  = in_data[IN_SRC_X_LSB +: COORD_W];
	assign src_y  = in_data[IN_SRC_Y_LSB +: COORD_W];
	assign rect_w = in_data[IN_RECT_W_LSB +: DIM_W];
	assign rect_h = in_data[IN_RECT_H_LSB +: DIM_W];
	assign dst_x  = in_data[IN_DST_X_LSB +: COORD_W];
	assign dst_y  = in_data[IN_DST_Y_LSB +: COORD_W];

	// Row offsets of the start positions
	assign dest_prod = {{(IDX_W + 1 - COORD_W){1'b0}}, dst_y}
		* {{(IDX_W + 1 - DIM_W){1'b0}}, cfg.scanline_pitch};
	assign src_prod  = {{(IDX_W + 1 - COORD_W){1'b0}}, src_y}
		* {{(IDX_W + 1 - DIM_W){1'b0}}, cfg.source_width};

	assign in_ready = !valid_s1 || push_ready;

	// Stage 1 valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload: source clip and row products
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1  <= in_func;
			w_s1     <= clip_span(DIM_W'(src_x), rect_w, cfg.source_width);
			h_s1     <= clip_span(DIM_W'(src_y), rect_h, cfg.source_height);
			dx_s1    <= dst_x;
			dy_s1    <= dst_y;
			sx_s1    <= src_x;
			dprod_s1 <= dest_prod[IDX_W-1:0];
			sprod_s1 <= src_prod[IDX_W-1:0];
			pixel_s1 <= in_data[IN_PIXEL_LSB +: PIXEL_BITS];
		end
	end

	// Screen clip, saturation and start indices
	always_comb begin
		w_scr = clip_span(DIM_W'(dx_s1), w_s1, cfg.screen_width);
		h_scr = clip_span(DIM_W'(dy_s1), h_s1, cfg.screen_height);
		w_sat = w_scr;
		h_sat = h_scr;
		if (32'(w_scr) > MAX_DIM) begin
			w_sat = DIM_W'(MAX_DIM);
		end
		if (32'(h_scr) > MAX_DIM) begin
			h_sat = DIM_W'(MAX_DIM);
		end
		cmd.empty       = (w_sat == '0) || (h_sat == '0);
		cmd.width       = w_sat;
		cmd.height      = h_sat;
		cmd.dest_base   = dprod_s1 + IDX_W'(dx_s1);
		cmd.source_base = sprod_s1 + IDX_W'(sx_s1);
		if (cmd.empty) begin
			cmd.width       = '0;
			cmd.height      = '0;
			cmd.dest_base   = '0;
			cmd.source_base = '0;
		end
	end

	assign push_valid = valid_s1;
	assign push_data  = {func_s1 == FUNC_COMMAND, cmd, pixel_s1};

endmodule
`default_nettype wire

@@ design/cckb_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cckb_queue: short first-in first-out queue
// Decouples the front part from the back part so either may stall.
// ----------------------------------------------------------------------------
module cckb_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 2
)(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	output logic                   push_ready,
	input  wire logic [DATA_W-1:0] push_data,
	output logic                   pop_valid,
	input  wire logic              pop_ready,
	output logic [DATA_W-1:0]      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ design/cckb_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cckb_back: blit execution and output register
// Takes classified words from the queue, tracks the raster position of the
// running blit, forms indices and the write enable, and holds each result
// word in an output register until it is taken.
// ----------------------------------------------------------------------------
module cckb_back
	import cckb_pkg::*;
#(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	parameter int QDATA_W    = 1 + $bits(cmd_t) + PIXEL_BITS
)(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               pop_valid,
	output logic                    pop_ready,
	input  wire logic [QDATA_W-1:0] pop_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [OUT_TDATA_W-1:0]  out_data,
	output logic                    out_last
);

	logic                  is_cmd;
	cmd_t                  cmd;
	logic [PIXEL_BITS-1:0] pixel;
	logic                  take;
	logic                  keyed;
	logic                  last_col;
	logic                  last;

	// Blit state
	logic             active_q;
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic [DIM_W-1:0] cols_q;
	logic [DIM_W-1:0] rows_q;
	logic [IDX_W-1:0] dbase_q;
	logic [IDX_W-1:0] sbase_q;

	// Output register
	logic                  out_valid_q;
	logic [IDX_W-1:0]      dest_q;
	logic [IDX_W-1:0]      src_q;
	logic [PIXEL_BITS-1:0] pix_q;
	logic                  we_q;
	logic                  last_q;
	logic [DIM_W-1:0]      cw_q;
	logic [DIM_W-1:0]      ch_q;
	logic                  empty_q;

	assign {is_cmd, cmd, pixel} = pop_data;
	assign pop_ready = !out_valid_q || out_ready;
	assign take      = pop_valid && pop_ready;

	// Per-pixel decisions
	assign keyed    = (cfg.color_key[PIXEL_BITS-1:0] != '0)
		&& (pixel == cfg.color_key[PIXEL_BITS-1:0]);
	assign last_col = ({1'b0, col_q} + 1'b1) >= {1'b0, cols_q};
	assign last     = last_col && (({1'b0, row_q} + 1'b1) >= {1'b0, rows_q});

	// Blit state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			cols_q   <= '0;
			rows_q   <= '0;
			dbase_q  <= '0;
			sbase_q  <= '0;
		end else if (take && is_cmd) begin
			active_q <= !cmd.empty;
			col_q    <= '0;
			row_q    <= '0;
			cols_q   <= cmd.width;
			rows_q   <= cmd.height;
			dbase_q  <= cmd.dest_base;
			sbase_q  <= cmd.source_base;
		end else if (take && active_q) begin
			if (last_col) begin
				col_q   <= '0;
				row_q   <= row_q + 1'b1;
				dbase_q <= dbase_q + IDX_W'(cfg.scanline_pitch);
				sbase_q <= sbase_q + IDX_W'(cfg.source_width);
			end else begin
				col_q <= col_q + 1'b1;
			end
			if (last) begin
				active_q <= 1'b0;
				row_q    <= '0;
			end
		end
	end

	// Output valid flag: idle pixels produce no word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= take && (is_cmd || active_q);
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (take) begin
			if (is_cmd) begin
				dest_q  <= cmd.dest_base;
				src_q   <= cmd.source_base;
				pix_q   <= '0;
				we_q    <= 1'b0;
				last_q  <= 1'b0;
				cw_q    <= cmd.width;
				ch_q    <= cmd.height;
				empty_q <= cmd.empty;
			end else begin
				dest_q  <= dbase_q + IDX_W'(col_q);
				src_q   <= sbase_q + IDX_W'(col_q);
				pix_q   <= pixel;
				we_q    <= !keyed;
				last_q  <= last;
				cw_q    <= '0;
				ch_q    <= '0;
				empty_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_last  = last_q;
	assign out_data  = {{OUT_PAD_W{1'b0}}, empty_q, ch_q, cw_q, we_q, PIX_W'(pix_q),
		src_q, dest_q};

endmodule
`default_nettype wire
